FILE: hdl/sha256bc_pkg.sv
// Shared types, round constants and sigma functions for the SHA-256 block compressor.
// No dependencies; used by sha256bc_round and sha256_block_compress_top.
package sha256bc_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  vars_t;   // [0]=a .. [7]=h
  typedef logic [5:0]        rnd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned WIN_DEPTH  = 16;

  localparam logic [3:0] LAST_MSG_WORD = 4'd15;
  localparam logic [2:0] LAST_HASH_IDX = 3'd7;
  localparam rnd_t       LAST_ROUND    = 6'd63;
  localparam logic       MODE_CHAIN    = 1'b0;
  localparam logic       MODE_MSG      = 1'b1;

  localparam word_t K_TABLE [0:63] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t round_k(input rnd_t t);
    return K_TABLE[t];
  endfunction

  // upper-case sigmas act on the working variables
  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // lower-case sigmas act on the message schedule
  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: hdl/sha256bc_round.sv
// One SHA-256 compression round, shared over all 64 rounds by the sequencer.
// Depends on sha256bc_pkg; K[t]+W[t] arrives pre-summed and registered.
module sha256bc_round (
  input  sha256bc_pkg::vars_t v_i,
  input  sha256bc_pkg::word_t kw_i,
  output sha256bc_pkg::vars_t v_o
);

  sha256bc_pkg::word_t ch;
  sha256bc_pkg::word_t maj;
  sha256bc_pkg::word_t t1;
  sha256bc_pkg::word_t t2;

  always_comb begin
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + sha256bc_pkg::big_sigma1(v_i[4]) + ch + kw_i;
    t2  = sha256bc_pkg::big_sigma0(v_i[0]) + maj;
  end

  always_comb begin
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

FILE: hdl/sha256_block_compress_top.sv
// SHA-256 block compressor: chaining load, word-serial message input, 64-round compression.
// Depends on sha256bc_pkg and sha256bc_round.
//
// Usage
//   Input channel (in_*): one transfer per word. in_tuser[0] is the mode:
//   0 writes chaining word in_tuser[3:1] (A=0 .. H=7) from in_tdata, 1 appends
//   in_tdata as the next big-endian message word of the current block.
//   Chaining words may be written at any time the block is ready, also
//   between message words; the pending block uses the latest values.
//   On the sixteenth message word the block compresses and the output
//   channel (out_*) then carries the eight updated chaining words, A first,
//   with out_tuser giving the index and out_tlast set on H.
// Timing
//   Load transfers are accepted at one per cycle. After the sixteenth word
//   the sequencer primes the schedule (PREP), runs the 64 rounds at one per
//   cycle through the single round unit (ROUND), adds the feed-forward
//   (FINAL), then makes the eight result transfers (OUT).
//   in_tready stays low from the last word until H has been taken; a stall
//   on out_tready simply holds the current word.
// Reset
//   rst_n (synchronous, active low) clears the chaining value to zero, the
//   word count, and returns the sequencer to idle.
module sha256_block_compress_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic [3:0]  in_tuser,   // [0] mode, [3:1] word_index
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] hash_word
  output logic [2:0]  out_tuser,  // [2:0] hash_index
  output logic        out_tlast   // last
);

  sha256bc_pkg::state_t state_r, state_nxt;
  logic [3:0]           cnt_r, cnt_nxt;      // message words in current block
  sha256bc_pkg::rnd_t   rnd_r, rnd_nxt;      // round counter
  logic [2:0]           oidx_r, oidx_nxt;    // result index
  sha256bc_pkg::vars_t  cv_r;                // chaining value
  sha256bc_pkg::vars_t  v_r;                 // working variables
  sha256bc_pkg::vars_t  v_round;
  sha256bc_pkg::word_t  kw_r, kw_nxt;        // K[t]+W[t] for the next round
  sha256bc_pkg::word_t  win_r [0:15];        // schedule window, oldest at 0
  sha256bc_pkg::word_t  sched_w;
  sha256bc_pkg::rnd_t   sidx;

  logic in_xfer;
  logic out_xfer;
  logic msg_load;
  logic chain_load;
  logic sched_step;
  logic last_word;

  assign in_xfer    = in_tvalid & in_tready;
  assign out_xfer   = out_tvalid & out_tready;
  assign msg_load   = in_xfer & (in_tuser[0] == sha256bc_pkg::MODE_MSG);
  assign chain_load = in_xfer & (in_tuser[0] == sha256bc_pkg::MODE_CHAIN);
  assign last_word  = msg_load & (cnt_r == sha256bc_pkg::LAST_MSG_WORD);

  // ---- shared round unit
  sha256bc_round u_round (
    .v_i  (v_r),
    .kw_i (kw_r),
    .v_o  (v_round)
  );

  // ---- message schedule, one word ahead of the rounds
  always_comb begin
    sidx = (state_r == sha256bc_pkg::ST_PREP) ? '0 : rnd_r + 6'd1;
    if (sidx < 6'(sha256bc_pkg::WIN_DEPTH)) begin
      sched_w = win_r[0];
    end else begin
      sched_w = win_r[0] + sha256bc_pkg::small_sigma0(win_r[1]) + win_r[9]
              + sha256bc_pkg::small_sigma1(win_r[14]);
    end
    kw_nxt = sha256bc_pkg::round_k(sidx) + sched_w;
  end

  // ---- sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256bc_pkg::ST_IDLE: begin
        if (last_word) state_nxt = sha256bc_pkg::ST_PREP;
      end
      sha256bc_pkg::ST_PREP:  state_nxt = sha256bc_pkg::ST_ROUND;
      sha256bc_pkg::ST_ROUND: begin
        if (rnd_r == sha256bc_pkg::LAST_ROUND) state_nxt = sha256bc_pkg::ST_FINAL;
      end
      sha256bc_pkg::ST_FINAL: state_nxt = sha256bc_pkg::ST_OUT;
      sha256bc_pkg::ST_OUT: begin
        if (out_xfer && oidx_r == sha256bc_pkg::LAST_HASH_IDX) begin
          state_nxt = sha256bc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256bc_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    sched_step = 1'b0;
    case (state_r)
      sha256bc_pkg::ST_IDLE:  in_tready  = 1'b1;
      sha256bc_pkg::ST_PREP:  sched_step = 1'b1;
      sha256bc_pkg::ST_ROUND: sched_step = 1'b1;
      sha256bc_pkg::ST_FINAL: sched_step = 1'b0;
      sha256bc_pkg::ST_OUT:   out_tvalid = 1'b1;
      default: begin
        in_tready  = 1'b0;
        out_tvalid = 1'b0;
      end
    endcase
  end

  // ---- counters
  always_comb begin
    cnt_nxt  = cnt_r;
    rnd_nxt  = rnd_r;
    oidx_nxt = oidx_r;
    if (msg_load) cnt_nxt = cnt_r + 4'd1;   // wraps to zero after a block
    if (state_r == sha256bc_pkg::ST_ROUND) rnd_nxt = rnd_r + 6'd1;
    if (state_r == sha256bc_pkg::ST_FINAL) oidx_nxt = '0;
    else if (out_xfer) oidx_nxt = oidx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256bc_pkg::ST_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      cv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      if (chain_load) begin
        cv_r[in_tuser[3:1]] <= in_tdata;
      end else if (state_r == sha256bc_pkg::ST_FINAL) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] + v_r[i];
      end
    end
  end

  // ---- datapath (no reset needed)
  always_ff @(posedge clk) begin
    if (msg_load || sched_step) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= msg_load ? in_tdata : sched_w;
    end
    if (sched_step) kw_r <= kw_nxt;
    if (state_r == sha256bc_pkg::ST_PREP) v_r <= cv_r;
    else if (state_r == sha256bc_pkg::ST_ROUND) v_r <= v_round;
  end

  assign out_tdata = cv_r[oidx_r];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == sha256bc_pkg::LAST_HASH_IDX);

  // ---- assertions
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result sides active together");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    last_word |=> state_r == sha256bc_pkg::ST_PREP)
    else $error("sixteenth word did not start compression");

  a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha256bc_pkg::ST_FINAL |-> rnd_r == '0 && cnt_r == '0)
    else $error("feed-forward reached with round or word count off");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> in_tready)
    else $error("not ready after final result transfer");

  a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tuser == '0)
    else $error("result sequence does not start at A");

endmodule
